// File: rtl/cac_pkg.sv
// Shared types, register codes and helpers of the cartridge address counter.
package cac_pkg;

   localparam int unsigned AddrWidth    = 21;
   localparam int unsigned BlockWidth   = 8;
   localparam int unsigned CounterWidth = 11;
   localparam int unsigned ShiftWidth   = 4;
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [ShiftWidth-1:0] PageShiftReset = 4'd10;
   localparam logic [ShiftWidth-1:0] PageShiftMin   = 4'd8;
   localparam logic [ShiftWidth-1:0] PageShiftMax   = 4'd11;
   localparam logic [AddrWidth-1:0]  AuxPages       = 21'd256;

   localparam logic [1:0] RegPageSizeLog2 = 2'd0;
   localparam logic [1:0] RegAuxBankEn    = 2'd1;
   localparam logic [1:0] RegCartSize     = 2'd2;

   localparam logic [0:0] OpStrobe = 1'b0;
   localparam logic [0:0] OpRead   = 1'b1;

   localparam int unsigned SysctlClockBit = 0;
   localparam int unsigned SysctlPowerBit = 1;
   localparam int unsigned IoShiftBit     = 1;
   localparam int unsigned IoBankSelBit   = 4;

   typedef struct packed {
      logic [ShiftWidth-1:0] page_size_log2;
      logic                  aux_bank_enable;
      logic [AddrWidth-1:0]  cart_size;
   } cfg_type;

   typedef struct packed {
      logic [0:0] op;
      logic [7:0] sysctl;
      logic [7:0] io_data;
   } item_type;

   typedef struct packed {
      logic [AddrWidth-1:0]    byte_address;
      logic                    address_valid;
      logic [BlockWidth-1:0]   block_number;
      logic [CounterWidth-1:0] byte_counter;
   } result_type;

   function automatic logic [ShiftWidth-1:0] page_shift(input logic [ShiftWidth-1:0] log2_value);
      logic [ShiftWidth-1:0] shift;
      shift = log2_value;
      if (log2_value < PageShiftMin || log2_value > PageShiftMax) begin
         shift = PageShiftReset;
      end
      return shift;
   endfunction

endpackage

// File: rtl/cartridge_address_counter_core.sv
// Top level of the cartridge address counter: input register, datapath, result register.
// A request is captured in the input register, its result in the result register.
// Throughput: one transaction per cycle unless a response waits, set by the state update.
// A waiting response holds the datapath; the input register takes one more request and then
// stalls the request side. Synchronous active-high reset clears block, counter, clock history,
// the configuration registers (page size 1024 bytes) and both valid flags.
module cartridge_address_counter_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [0:0]                       req_op,
   input  logic [7:0]                       req_sysctl,
   input  logic [7:0]                       req_io_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cac_pkg::AddrWidth-1:0]    rsp_byte_address,
   output logic                             rsp_address_valid,
   output logic [cac_pkg::BlockWidth-1:0]   rsp_block_number,
   output logic [cac_pkg::CounterWidth-1:0] rsp_byte_counter,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cac_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [cac_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [cac_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                             csr_pready
);

   cac_pkg::cfg_type    cfg;
   cac_pkg::item_type   item_ff;
   cac_pkg::result_type result;
   cac_pkg::result_type result_ff;
   logic                item_valid_ff;
   logic                rsp_valid_ff;
   logic                out_advance;
   logic                step_en;

   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign step_en     = item_valid_ff && out_advance;
   assign req_ready   = !item_valid_ff || out_advance;

   cac_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cac_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (out_advance) begin
            rsp_valid_ff <= item_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.op      <= req_op;
         item_ff.sysctl  <= req_sysctl;
         item_ff.io_data <= req_io_data;
      end
      if (step_en) begin
         result_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_address  = result_ff.byte_address;
   assign rsp_address_valid = result_ff.address_valid;
   assign rsp_block_number  = result_ff.block_number;
   assign rsp_byte_counter  = result_ff.byte_counter;

endmodule

// File: rtl/cac_csr.sv
// Configuration register file with its APB-style access port.
module cac_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cac_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [cac_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [cac_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready,
   output cac_pkg::cfg_type                    cfg
);

   cac_pkg::cfg_type cfg_ff;
   cac_pkg::cfg_type cfg_in;
   logic             write_en;
   logic [1:0]       reg_index;

   assign write_en  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            cac_pkg::RegPageSizeLog2: begin
               cfg_in.page_size_log2 = csr_pwdata[cac_pkg::ShiftWidth-1:0];
            end
            cac_pkg::RegAuxBankEn: begin
               cfg_in.aux_bank_enable = csr_pwdata[0];
            end
            cac_pkg::RegCartSize: begin
               cfg_in.cart_size = csr_pwdata[cac_pkg::AddrWidth-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_size_log2  <= cac_pkg::PageShiftReset;
         cfg_ff.aux_bank_enable <= 1'b0;
         cfg_ff.cart_size       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         cac_pkg::RegPageSizeLog2: begin
            csr_prdata = 32'(cfg_ff.page_size_log2);
         end
         cac_pkg::RegAuxBankEn: begin
            csr_prdata = 32'(cfg_ff.aux_bank_enable);
         end
         cac_pkg::RegCartSize: begin
            csr_prdata = 32'(cfg_ff.cart_size);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// File: rtl/cac_datapath.sv
// Block/counter state and address computation for one transaction.
module cac_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  cac_pkg::item_type   item,
   input  cac_pkg::cfg_type    cfg,
   output cac_pkg::result_type result
);

   logic [cac_pkg::BlockWidth-1:0]   block_ff,   block_in;
   logic [cac_pkg::CounterWidth-1:0] counter_ff, counter_in;
   logic                             clock_bit_ff, clock_bit_in;

   logic [cac_pkg::ShiftWidth-1:0]   shift;
   logic [cac_pkg::CounterWidth-1:0] mask;
   logic [cac_pkg::AddrWidth-1:0]    block_base;
   logic [cac_pkg::AddrWidth-1:0]    aux_base;
   logic [cac_pkg::AddrWidth-1:0]    addr;
   logic                             power;
   logic                             sclk;

   assign shift = cac_pkg::page_shift(cfg.page_size_log2);
   assign mask  = cac_pkg::CounterWidth'((12'd1 << shift) - 12'd1);
   assign power = item.sysctl[cac_pkg::SysctlPowerBit];
   assign sclk  = item.sysctl[cac_pkg::SysctlClockBit];

   assign block_base = cac_pkg::AddrWidth'(block_ff) << shift;
   assign aux_base   = (cfg.aux_bank_enable && item.io_data[cac_pkg::IoBankSelBit])
                       ? (cac_pkg::AuxPages << shift) : '0;
   assign addr       = block_base + cac_pkg::AddrWidth'(counter_ff & mask) + aux_base;

   always_comb begin
      block_in     = block_ff;
      counter_in   = counter_ff;
      clock_bit_in = clock_bit_ff;
      result       = '0;
      case (item.op)
         cac_pkg::OpStrobe: begin
            if (power) begin
               if (sclk && !clock_bit_ff) begin
                  block_in   = {block_ff[cac_pkg::BlockWidth-2:0],
                                item.io_data[cac_pkg::IoShiftBit]};
                  counter_in = '0;
               end
            end else begin
               block_in   = '0;
               counter_in = '0;
            end
            clock_bit_in = sclk;
         end
         cac_pkg::OpRead: begin
            counter_in           = (counter_ff + 11'd1) & mask;
            result.byte_address  = addr;
            result.address_valid = addr < cfg.cart_size;
         end
         default: begin
            block_in = block_ff;
         end
      endcase
      result.block_number = block_in;
      result.byte_counter = counter_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_ff     <= '0;
         counter_ff   <= '0;
         clock_bit_ff <= 1'b0;
      end else if (step_en) begin
         block_ff     <= block_in;
         counter_ff   <= counter_in;
         clock_bit_ff <= clock_bit_in;
      end
   end

endmodule

// File: rtl/cac_checker.sv
// Port-level checks of the cartridge address counter, bound to the top level.
module cac_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [cac_pkg::AddrWidth-1:0]    rsp_byte_address,
   input logic                             rsp_address_valid,
   input logic [cac_pkg::BlockWidth-1:0]   rsp_block_number,
   input logic [cac_pkg::CounterWidth-1:0] rsp_byte_counter
);

   reset_empties_output: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled while response slot empty");

   accepted_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> ##1 rsp_valid)
      else $error("accepted transaction did not reach the response");

   stalled_response_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_byte_address)
         && $stable(rsp_address_valid) && $stable(rsp_block_number)
         && $stable(rsp_byte_counter)))
      else $error("stalled response changed");

endmodule

bind cartridge_address_counter_core cac_checker u_cac_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_byte_address  (rsp_byte_address),
   .rsp_address_valid (rsp_address_valid),
   .rsp_block_number  (rsp_block_number),
   .rsp_byte_counter  (rsp_byte_counter)
);

// File: verif/tb_cartridge_address_counter_core.sv
// Self-checking testbench for the cartridge address counter core.
module tb_cartridge_address_counter_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QuietLimit = 3000;
   localparam int MaxIdle    = 14;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [0:0]                       req_op = cac_pkg::OpStrobe;
   logic [7:0]                       req_sysctl = 8'h00;
   logic [7:0]                       req_io_data = 8'h00;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [cac_pkg::AddrWidth-1:0]    rsp_byte_address;
   logic                             rsp_address_valid;
   logic [cac_pkg::BlockWidth-1:0]   rsp_block_number;
   logic [cac_pkg::CounterWidth-1:0] rsp_byte_counter;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [cac_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [cac_pkg::CsrDataWidth-1:0] csr_pwdata = '0;
   logic [cac_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                             csr_pready;

   cartridge_address_counter_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_sysctl        (req_sysctl),
      .req_io_data       (req_io_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_byte_address  (rsp_byte_address),
      .rsp_address_valid (rsp_address_valid),
      .rsp_block_number  (rsp_block_number),
      .rsp_byte_counter  (rsp_byte_counter),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted counter state and register copy
   logic [cac_pkg::ShiftWidth-1:0]   page_log2_cfg = cac_pkg::PageShiftReset;
   logic                             aux_bank_cfg = 1'b0;
   logic [cac_pkg::AddrWidth-1:0]    cart_bytes_cfg = '0;
   logic [cac_pkg::BlockWidth-1:0]   block_q = '0;
   logic [cac_pkg::CounterWidth-1:0] counter_q = '0;
   logic                             last_clock_q = 1'b0;

   cac_pkg::item_type   pending_event_q[$];
   cac_pkg::result_type expected_access_q[$];
   cac_pkg::item_type   next_event;
   cac_pkg::result_type want_access;

   bit send_idle = 1'b0;
   bit rsp_idle = 1'b0;
   int send_gap = 0;
   int rsp_stall = 0;
   int rsp_hold = 0;
   int rsp_taken = 0;
   int quiet_cycles = 0;
   int items_queued = 0;
   int settings_used = 0;
   int reads_sent = 0;
   int strobes_sent = 0;
   int block_shifts = 0;
   int page_wraps = 0;
   int results_checked = 0;
   int mismatches = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 40) begin
         $display("mismatch in %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
      end
   endtask

   task automatic predict_cart_access(input logic [0:0] op, input logic [7:0] sysctl,
                                      input logic [7:0] io_data);
      int unsigned         eff_shift;
      int unsigned         page_mask;
      int unsigned         addr;
      cac_pkg::result_type r;
      r = '0;
      if (op == cac_pkg::OpStrobe) begin
         strobes_sent++;
         if (sysctl[cac_pkg::SysctlPowerBit]) begin
            if (sysctl[cac_pkg::SysctlClockBit] && !last_clock_q) begin
               block_q = {block_q[cac_pkg::BlockWidth-2:0], io_data[cac_pkg::IoShiftBit]};
               counter_q = '0;
               block_shifts++;
            end
         end else begin
            block_q = '0;
            counter_q = '0;
         end
         last_clock_q = sysctl[cac_pkg::SysctlClockBit];
      end else begin
         reads_sent++;
         eff_shift = 32'(page_log2_cfg);
         if (page_log2_cfg < cac_pkg::PageShiftMin || page_log2_cfg > cac_pkg::PageShiftMax) begin
            eff_shift = 32'(cac_pkg::PageShiftReset);
         end
         page_mask = (1 << eff_shift) - 1;
         addr = 32'(block_q);
         addr = (addr << eff_shift) + (counter_q & page_mask);
         if (io_data[cac_pkg::IoBankSelBit] && aux_bank_cfg) begin
            addr = addr + (32'(cac_pkg::AuxPages) << eff_shift);
         end
         r.byte_address = addr[cac_pkg::AddrWidth-1:0];
         r.address_valid = (addr[cac_pkg::AddrWidth-1:0] < cart_bytes_cfg);
         counter_q = cac_pkg::CounterWidth'((counter_q + 1) & page_mask);
         if (counter_q == 0) begin
            page_wraps++;
         end
      end
      r.block_number = block_q;
      r.byte_counter = counter_q;
      expected_access_q.insert(expected_access_q.size(), r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_cart_access(req_op, req_sysctl, req_io_data);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_event_q.size() > 0) begin
               next_event = pending_event_q.pop_front();
               req_valid <= 1'b1;
               req_op <= next_event.op;
               req_sysctl <= next_event.sysctl;
               req_io_data <= next_event.io_data;
               send_gap = send_idle ? $urandom_range(0, MaxIdle) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long hold-offs fill the block and stall the request side
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_taken++;
            rsp_stall = rsp_idle ? $urandom_range(0, MaxIdle) : 0;
            if (rsp_taken % 700 == 120) begin
               rsp_hold = 400;
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_access_q.size() == 0) begin
            report_mismatch("transaction with none expected", 32'(rsp_byte_address), 32'd0);
         end else begin
            want_access = expected_access_q.pop_front();
            results_checked++;
            if (rsp_byte_address !== want_access.byte_address) begin
               report_mismatch("byte_address", 32'(rsp_byte_address),
                               32'(want_access.byte_address));
            end
            if (rsp_address_valid !== want_access.address_valid) begin
               report_mismatch("address_valid", 32'(rsp_address_valid),
                               32'(want_access.address_valid));
            end
            if (rsp_block_number !== want_access.block_number) begin
               report_mismatch("block_number", 32'(rsp_block_number),
                               32'(want_access.block_number));
            end
            if (rsp_byte_counter !== want_access.byte_counter) begin
               report_mismatch("byte_counter", 32'(rsp_byte_counter),
                               32'(want_access.byte_counter));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("timeout: no transaction for %0d cycles", QuietLimit);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] want;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         cac_pkg::RegPageSizeLog2: begin
            page_log2_cfg = value[cac_pkg::ShiftWidth-1:0];
            want = 32'(page_log2_cfg);
         end
         cac_pkg::RegAuxBankEn: begin
            aux_bank_cfg = value[0];
            want = 32'(aux_bank_cfg);
         end
         default: begin
            cart_bytes_cfg = value[cac_pkg::AddrWidth-1:0];
            want = 32'(cart_bytes_cfg);
         end
      endcase
      if (csr_prdata !== want) begin
         report_mismatch("register readback", csr_prdata, want);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic queue_event(input logic [0:0] op, input logic [7:0] sysctl,
                              input logic [7:0] io);
      cac_pkg::item_type ev;
      ev.op = op;
      ev.sysctl = sysctl;
      ev.io_data = io;
      pending_event_q.insert(pending_event_q.size(), ev);
      items_queued++;
   endtask

   task automatic queue_page_select(input bit full);
      int          pulses;
      logic [7:0]  sys;
      pulses = full ? cac_pkg::BlockWidth : $urandom_range(1, cac_pkg::BlockWidth - 1);
      sys = 8'($urandom);
      sys[cac_pkg::SysctlPowerBit] = 1'b1;
      sys[cac_pkg::SysctlClockBit] = 1'b0;
      queue_event(cac_pkg::OpStrobe, sys, 8'($urandom));
      repeat (pulses) begin
         sys = 8'($urandom);
         sys[cac_pkg::SysctlPowerBit] = 1'b1;
         sys[cac_pkg::SysctlClockBit] = 1'b1;
         queue_event(cac_pkg::OpStrobe, sys, 8'($urandom));
         sys = 8'($urandom);
         sys[cac_pkg::SysctlPowerBit] = 1'b1;
         sys[cac_pkg::SysctlClockBit] = 1'b0;
         queue_event(cac_pkg::OpStrobe, sys, 8'($urandom));
      end
   endtask

   task automatic queue_read_burst();
      int count;
      count = ($urandom_range(0, 14) == 0) ? $urandom_range(257, 300) : $urandom_range(1, 24);
      repeat (count) begin
         queue_event(cac_pkg::OpRead, 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic queue_random_group();
      int          pick;
      logic [7:0]  sys;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         queue_page_select(1'b1);
         queue_read_burst();
      end else if (pick < 65) begin
         queue_read_burst();
      end else if (pick < 80) begin
         queue_page_select(1'b0);
      end else if (pick < 88) begin
         sys = 8'($urandom);
         sys[cac_pkg::SysctlPowerBit] = 1'b0;
         queue_event(cac_pkg::OpStrobe, sys, 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 6)) begin
            queue_event(1'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_event_q.size() > 0 || req_valid || expected_access_q.size() > 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic run_setting(input logic [3:0] log2_val, input logic aux_val,
                              input logic [20:0] bytes_val, input bit s_idle,
                              input bit r_idle, input int count);
      int first;
      set_register(cac_pkg::RegPageSizeLog2, 32'(log2_val));
      set_register(cac_pkg::RegAuxBankEn, 32'(aux_val));
      set_register(cac_pkg::RegCartSize, 32'(bytes_val));
      send_idle = s_idle;
      rsp_idle = r_idle;
      settings_used++;
      first = items_queued;
      while (items_queued - first < count) begin
         queue_random_group();
      end
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      set_register(cac_pkg::RegPageSizeLog2, 32'd8);
      set_register(cac_pkg::RegAuxBankEn, 32'd1);
      set_register(cac_pkg::RegCartSize, 32'd65536);
      settings_used++;
      send_idle = 1'b1;
      rsp_idle = 1'b1;
      queue_event(cac_pkg::OpStrobe, 8'h00, 8'h00);
      queue_event(cac_pkg::OpStrobe, 8'h02, 8'hfd);
      queue_event(cac_pkg::OpStrobe, 8'h03, 8'h02);
      queue_event(cac_pkg::OpStrobe, 8'hfe, 8'h00);
      queue_event(cac_pkg::OpStrobe, 8'hff, 8'hff);
      queue_event(cac_pkg::OpStrobe, 8'h03, 8'hff);
      queue_event(cac_pkg::OpRead, 8'h00, 8'h00);
      queue_event(cac_pkg::OpRead, 8'h00, 8'h10);
      queue_event(cac_pkg::OpRead, 8'hff, 8'hff);
      queue_event(cac_pkg::OpRead, 8'h00, 8'hef);
      queue_event(cac_pkg::OpStrobe, 8'h01, 8'h02);
      queue_event(cac_pkg::OpStrobe, 8'h03, 8'h02);
      queue_event(cac_pkg::OpRead, 8'h00, 8'h10);
      queue_event(cac_pkg::OpStrobe, 8'h02, 8'h00);
      queue_event(cac_pkg::OpStrobe, 8'h03, 8'h02);
      queue_event(cac_pkg::OpRead, 8'h00, 8'h00);
      queue_event(cac_pkg::OpStrobe, 8'h00, 8'hff);
      queue_event(cac_pkg::OpRead, 8'h00, 8'h10);
      wait_drained();

      run_setting(4'd8, 1'b1, 21'd1048576, 1'b1, 1'b1, 260);
      run_setting(4'd11, 1'b1, 21'd300000, 1'b0, 1'b0, 260);
      run_setting(4'd9, 1'b0, 21'd0, 1'b1, 1'b0, 260);
      run_setting(4'd15, 1'b1, 21'h1fffff, 1'b0, 1'b1, 260);
      run_setting(4'd0, 1'b0, 21'($urandom_range(1, 1048576)), 1'b1, 1'b1, 260);
      run_setting(4'd10, 1'b1, 21'd1048575, 1'b1, 1'b1, 260);

      $display("covered %0d transactions under %0d register settings:",
               items_queued, settings_used);
      $display("  %0d reads (%0d page wraps), %0d strobes (%0d block shifts), %0d compared",
               reads_sent, page_wraps, strobes_sent, block_shifts, results_checked);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
